[rtl/hfw_pkg.sv]
// Shared constants and types of the handoff FIFO with waiting consumers.
`default_nettype none
package hfw_pkg;

    localparam int ITEM_DEPTH_DEF   = 16;
    localparam int WAITER_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF  = 32;

    localparam int ID_WIDTH     = 4;
    localparam int STATUS_WIDTH = 2;
    localparam int SERVED_WIDTH = 32;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_DELIVERED = 2'd0,
        ST_PUT_FULL  = 2'd1,
        ST_TAKE_FULL = 2'd2
    } t_status;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_TAKE = 1'b1;

endpackage
`default_nettype wire

[rtl/hfw_if.sv]
// Request and result channel interfaces of the handoff FIFO.
`default_nettype none
interface hfw_in_if
    import hfw_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [VALUE_WIDTH-1:0] item_value;
    logic [ID_WIDTH-1:0]    consumer_id;

    modport source (output valid, output kind, output item_value, output consumer_id,
                    input ready);
    modport sink   (input valid, input kind, input item_value, input consumer_id,
                    output ready);
endinterface

interface hfw_out_if
    import hfw_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [STATUS_WIDTH-1:0] status;
    logic [VALUE_WIDTH-1:0]  delivered_value;
    logic [ID_WIDTH-1:0]     target_consumer;
    logic [SERVED_WIDTH-1:0] served_count;

    modport source (output valid, output status, output delivered_value,
                    output target_consumer, output served_count, input ready);
    modport sink   (input valid, input status, input delivered_value,
                    input target_consumer, input served_count, output ready);
endinterface
`default_nettype wire

[rtl/hfw_ram.sv]
// Single-port-write, registered-read memory for the item and waiter stores.
`default_nettype none
module hfw_ram
    import hfw_pkg::*;
#(
    parameter int WIDTH = VALUE_WIDTH_DEF,
    parameter int DEPTH = ITEM_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/handoff_fifo_with_waiters.sv]
// Top level: handoff FIFO that pairs put words with waiting take requests.
//
// A put is handed to the oldest waiting consumer, or else stored; a take gets the
// oldest stored item, or else the consumer is queued. A put or take that is stored,
// queued or refused needs no store read; a delivery reads the head entry from a
// synchronous store with a registered read, and input ready stays low while that
// read is outstanding. Ready also drops while a result sits in the output register
// and the sink does not take it. Both stores start undefined and need no clearing
// pass after reset.
`default_nettype none
module handoff_fifo_with_waiters
    import hfw_pkg::*;
#(
    parameter int ITEM_DEPTH   = ITEM_DEPTH_DEF,
    parameter int WAITER_DEPTH = WAITER_DEPTH_DEF,
    parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hfw_in_if.sink     i_in,
    hfw_out_if.source  o_out
);

    localparam int IA = $clog2(ITEM_DEPTH);
    localparam int IC = $clog2(ITEM_DEPTH + 1);
    localparam int WA = $clog2(WAITER_DEPTH);
    localparam int WC = $clog2(WAITER_DEPTH + 1);

    logic [IA-1:0]           r_item_head,  n_item_head;
    logic [IC-1:0]           r_item_count, n_item_count;
    logic [WA-1:0]           r_wait_head,  n_wait_head;
    logic [WC-1:0]           r_wait_count, n_wait_count;
    logic [SERVED_WIDTH-1:0] r_served,     n_served;

    logic                    r_rd_pend,    n_rd_pend;
    logic                    r_rd_item,    n_rd_item;
    logic [VALUE_WIDTH-1:0]  r_hold_value, n_hold_value;
    logic [ID_WIDTH-1:0]     r_hold_id,    n_hold_id;

    logic                    r_out_valid,  n_out_valid;
    t_status                 r_out_status, n_out_status;
    logic [VALUE_WIDTH-1:0]  r_out_value,  n_out_value;
    logic [ID_WIDTH-1:0]     r_out_target, n_out_target;
    logic [SERVED_WIDTH-1:0] r_out_count,  n_out_count;

    logic                    w_accept;
    logic [IA:0]             w_item_sum;
    logic [IA-1:0]           w_item_tail;
    logic [WA:0]             w_wait_sum;
    logic [WA-1:0]           w_wait_tail;

    logic                    w_item_we, w_item_re;
    logic                    w_wait_we, w_wait_re;
    logic [VALUE_WIDTH-1:0]  w_item_rdata;
    logic [ID_WIDTH-1:0]     w_wait_rdata;

    assign i_in.ready = !r_rd_pend && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_item_sum  = {1'b0, r_item_head} + (IA + 1)'(r_item_count);
    assign w_item_tail = (w_item_sum >= (IA + 1)'(ITEM_DEPTH))
                       ? IA'(w_item_sum - (IA + 1)'(ITEM_DEPTH)) : IA'(w_item_sum);
    assign w_wait_sum  = {1'b0, r_wait_head} + (WA + 1)'(r_wait_count);
    assign w_wait_tail = (w_wait_sum >= (WA + 1)'(WAITER_DEPTH))
                       ? WA'(w_wait_sum - (WA + 1)'(WAITER_DEPTH)) : WA'(w_wait_sum);

    always_comb begin
        n_item_head  = r_item_head;
        n_item_count = r_item_count;
        n_wait_head  = r_wait_head;
        n_wait_count = r_wait_count;
        n_served     = r_served;
        n_rd_pend    = 1'b0;
        n_rd_item    = r_rd_item;
        n_hold_value = r_hold_value;
        n_hold_id    = r_hold_id;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_target = r_out_target;
        n_out_count  = r_out_count;
        w_item_we    = 1'b0;
        w_item_re    = 1'b0;
        w_wait_we    = 1'b0;
        w_wait_re    = 1'b0;

        if (r_rd_pend) begin
            n_out_valid  = 1'b1;
            n_out_status = ST_DELIVERED;
            n_out_value  = r_rd_item ? w_item_rdata : r_hold_value;
            n_out_target = r_rd_item ? r_hold_id : w_wait_rdata;
            n_out_count  = r_served;
        end else if (w_accept) begin
            if (i_in.kind == KIND_PUT) begin
                if (r_wait_count != '0) begin
                    w_wait_re    = 1'b1;
                    n_wait_head  = (r_wait_head == WA'(WAITER_DEPTH - 1))
                                 ? '0 : r_wait_head + 1'b1;
                    n_wait_count = r_wait_count - 1'b1;
                    n_served     = r_served + 1'b1;
                    n_rd_pend    = 1'b1;
                    n_rd_item    = 1'b0;
                    n_hold_value = i_in.item_value;
                end else if (r_item_count == IC'(ITEM_DEPTH)) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_PUT_FULL;
                    n_out_value  = '0;
                    n_out_target = '0;
                    n_out_count  = r_served;
                end else begin
                    w_item_we    = 1'b1;
                    n_item_count = r_item_count + 1'b1;
                end
            end else begin
                if (r_item_count != '0) begin
                    w_item_re    = 1'b1;
                    n_item_head  = (r_item_head == IA'(ITEM_DEPTH - 1))
                                 ? '0 : r_item_head + 1'b1;
                    n_item_count = r_item_count - 1'b1;
                    n_served     = r_served + 1'b1;
                    n_rd_pend    = 1'b1;
                    n_rd_item    = 1'b1;
                    n_hold_id    = i_in.consumer_id;
                end else if (r_wait_count == WC'(WAITER_DEPTH)) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_TAKE_FULL;
                    n_out_value  = '0;
                    n_out_target = i_in.consumer_id;
                    n_out_count  = r_served;
                end else begin
                    w_wait_we    = 1'b1;
                    n_wait_count = r_wait_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_head  <= '0;
            r_item_count <= '0;
            r_wait_head  <= '0;
            r_wait_count <= '0;
            r_served     <= '0;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_item_head  <= n_item_head;
            r_item_count <= n_item_count;
            r_wait_head  <= n_wait_head;
            r_wait_count <= n_wait_count;
            r_served     <= n_served;
            r_rd_pend    <= n_rd_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_item    <= n_rd_item;
        r_hold_value <= n_hold_value;
        r_hold_id    <= n_hold_id;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_target <= n_out_target;
        r_out_count  <= n_out_count;
    end

    hfw_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (ITEM_DEPTH)
    ) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (w_item_we),
        .i_waddr (w_item_tail),
        .i_wdata (i_in.item_value),
        .i_re    (w_item_re),
        .i_raddr (r_item_head),
        .o_rdata (w_item_rdata)
    );

    hfw_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (WAITER_DEPTH)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (w_wait_we),
        .i_waddr (w_wait_tail),
        .i_wdata (i_in.consumer_id),
        .i_re    (w_wait_re),
        .i_raddr (r_wait_head),
        .o_rdata (w_wait_rdata)
    );

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_status;
    assign o_out.delivered_value = r_out_value;
    assign o_out.target_consumer = r_out_target;
    assign o_out.served_count    = r_out_count;

endmodule
`default_nettype wire

[rtl/hfw_checker.sv]
// Port-level checks of the handoff FIFO result channel, bound to the top level.
`default_nettype none
module hfw_checker
    import hfw_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire logic [STATUS_WIDTH-1:0] i_out_status,
    input wire logic [VALUE_WIDTH-1:0]  i_out_value,
    input wire logic [ID_WIDTH-1:0]     i_out_target,
    input wire logic [SERVED_WIDTH-1:0] i_out_count
);

    logic                    r_seen;
    logic [SERVED_WIDTH-1:0] r_last;
    logic                    w_delivered;

    assign w_delivered = i_out_valid && i_out_ready && (i_out_status == ST_DELIVERED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_last <= '0;
        end else if (w_delivered) begin
            r_seen <= 1'b1;
            r_last <= i_out_count;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_status) && $stable(i_out_value)
            && $stable(i_out_target) && $stable(i_out_count))
        else $error("stalled result word changed");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_DELIVERED) |-> (i_out_value == '0))
        else $error("refused result carries a value");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_delivered && r_seen |-> (i_out_count == r_last + 1'b1))
        else $error("served count skipped on delivery");

endmodule

bind handoff_fifo_with_waiters hfw_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_hfw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_value  (o_out.delivered_value),
    .i_out_target (o_out.target_consumer),
    .i_out_count  (o_out.served_count)
);
`default_nettype wire
